@@ hw/rtl/line_follow_distance_keeping_drive_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line follow drive
// Shared macros that wrap concurrent assertions on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_DISTANCE_KEEPING_DRIVE_ASSERT_SVH
`define LINE_FOLLOW_DISTANCE_KEEPING_DRIVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line follow drive: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line follow drive: next-cycle check failed");

`endif

@@ hw/rtl/lfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfd_pkg
// Widths, codes and constants shared by the line follow drive modules.
// ----------------------------------------------------------------------------
package lfd_pkg;

    // Field widths
    localparam int CAP_W    = 16;
    localparam int DIST_W   = 11;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int DRV_W    = 3;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // PID datapath widths
    localparam int ERR_W    = DIST_W + 1;
    localparam int SLOPE_W  = ERR_W + 1;
    localparam int SUM_W    = 32;
    localparam int POW_W    = 41;
    localparam int LO_W     = 24;
    localparam int HI_W     = POW_W - LO_W;
    localparam int MUL_A_W  = SUM_W + 1;
    localparam int MUL_B_W  = GAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 58;
    localparam int FRAC_Q88 = 8;
    localparam int FRAC_Q16 = 16;

    // Echo timing: the pulse width is divided by a reciprocal multiplication
    // that is exact over the whole timer range.
    localparam int ECHO_DIVISOR = 58;
    localparam int ECHO_SHIFT   = CAP_W + $clog2(ECHO_DIVISOR);
    localparam int ECHO_RECIP   = ((1 << ECHO_SHIFT) + ECHO_DIVISOR - 1) / ECHO_DIVISOR;
    localparam int RECIP_W      = CAP_W + 1;
    localparam int ECHO_PROD_W  = CAP_W + ECHO_SHIFT;
    localparam int DIST_MAX     = (1 << DIST_W) - 1;

    // Wheel values
    localparam int PWM_TOP            = 999;
    localparam int WHEEL_L_STRAIGHT   = 78;
    localparam int WHEEL_R_STRAIGHT   = 71;
    localparam int WHEEL_L_LEFT       = 78;
    localparam int WHEEL_R_LEFT       = 67;
    localparam int WHEEL_R_SHARPLEFT  = 67;
    localparam int WHEEL_L_RIGHT      = 82;
    localparam int WHEEL_R_RIGHT      = 73;
    localparam int WHEEL_L_SHARPRIGHT = 83;

    // Register reset values
    localparam int R_SETPOINT = 10;
    localparam int R_STOPDIST = 10;
    localparam int R_KP       = 640;
    localparam int R_KI       = 0;
    localparam int R_KD       = 896;
    localparam int R_TRIM     = 5243;
    localparam int R_WINDUP   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_STOPDIST = 3'd1,
        CFG_KP       = 3'd2,
        CFG_KI       = 3'd3,
        CFG_KD       = 3'd4,
        CFG_TRIM     = 3'd5,
        CFG_WINDUP   = 3'd6
    } cfg_idx_t;

    typedef enum logic [DRV_W-1:0] {
        DRV_STOP     = 3'd0,
        DRV_STRAIGHT = 3'd1,
        DRV_LEFT     = 3'd2,
        DRV_RIGHT    = 3'd3,
        DRV_SLEFT    = 3'd4,
        DRV_SRIGHT   = 3'd5
    } drv_t;

    // Addend selection of the shared multiply-add unit
    typedef enum logic [1:0] {
        C_ZERO  = 2'd0,
        C_ACC   = 2'd1,
        C_LEFT  = 2'd2,
        C_RIGHT = 2'd3
    } csel_t;

    typedef struct packed {
        logic  en;        // write the result back into the accumulator
        csel_t csel;      // addend
        logic  use_acc;   // add the accumulator instead of the product
        logic  shift_hi;  // product weighs 2^LO_W
        logic  negate;    // subtract instead of add
    } mac_ctl_t;

endpackage

@@ hw/rtl/lfd_echo.sv @@
// ----------------------------------------------------------------------------
// lfd_echo
// Echo edge capture and reciprocal multiplication of the pulse width into cm.
// ----------------------------------------------------------------------------
module lfd_echo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lfd_pkg::CAP_W-1:0]   cap,
    output logic                        busy,
    output logic [lfd_pkg::DIST_W-1:0]  distance
);
    import lfd_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(ECHO_RECIP);

    logic                   await_rise_reg;
    logic [CAP_W-1:0]       rise_time_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   busy_reg;
    logic [CAP_W-1:0]       width_reg;

    logic [ECHO_PROD_W-1:0] prod;
    logic [CAP_W-1:0]       quo;
    logic [DIST_W-1:0]      dist_next;

    // The quotient is the product shifted down; it is exact for every width.
    always_comb
    begin
        prod = {{(ECHO_PROD_W - CAP_W){1'b0}}, width_reg}
               * {{(ECHO_PROD_W - RECIP_W){1'b0}}, RECIP};
        quo  = prod[ECHO_PROD_W-1:ECHO_SHIFT];
        if (quo > CAP_W'(DIST_MAX))
            dist_next = DIST_W'(DIST_MAX);
        else
            dist_next = quo[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_rise_reg <= 1'b1;
            rise_time_reg  <= '0;
            dist_reg       <= '0;
            busy_reg       <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            dist_reg <= dist_next;
        end
        else if (start)
        begin
            if (await_rise_reg)
            begin
                rise_time_reg  <= cap;
                await_rise_reg <= 1'b0;
            end
            else
            begin
                busy_reg       <= 1'b1;
                await_rise_reg <= 1'b1;
            end
        end
    end

    // Pulse width; the subtraction wraps modulo the timer width.
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start && !await_rise_reg)
            width_reg <= cap - rise_time_reg;
    end

    assign busy     = busy_reg;
    assign distance = dist_reg;

endmodule

@@ hw/rtl/lfd_mac.sv @@
// ----------------------------------------------------------------------------
// lfd_mac
// Shared signed multiply-add unit with its accumulator.
// ----------------------------------------------------------------------------
module lfd_mac (
    input  logic                                clk,
    input  lfd_pkg::mac_ctl_t                   ctl,
    input  logic signed [lfd_pkg::MUL_A_W-1:0]  a,
    input  logic signed [lfd_pkg::MUL_B_W-1:0]  b,
    output logic signed [lfd_pkg::ACC_W-1:0]    sum,
    output logic signed [lfd_pkg::ACC_W-1:0]    acc
);
    import lfd_pkg::*;

    localparam logic signed [ACC_W-1:0] K_LEFT  = ACC_W'(WHEEL_L_STRAIGHT) <<< FRAC_Q16;
    localparam logic signed [ACC_W-1:0] K_RIGHT = ACC_W'(WHEEL_R_STRAIGHT) <<< FRAC_Q16;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  x;
    logic signed [ACC_W-1:0]  addend;

    assign prod = a * b;

    always_comb
    begin
        prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
        if (ctl.use_acc)
            x = acc_reg;
        else if (ctl.shift_hi)
            x = prod_ext <<< LO_W;
        else
            x = prod_ext;
        case (ctl.csel)
            C_ZERO:  addend = '0;
            C_ACC:   addend = acc_reg;
            C_LEFT:  addend = K_LEFT;
            C_RIGHT: addend = K_RIGHT;
            default: addend = '0;
        endcase
        sum      = ctl.negate ? (addend - x) : (addend + x);
        acc_next = ctl.en ? sum : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/line_follow_distance_keeping_drive.sv @@
// ----------------------------------------------------------------------------
// line_follow_distance_keeping_drive
// Line following drive with ultrasonic distance keeping and a PID trim.
// ----------------------------------------------------------------------------
// Usage. One input channel (in_valid / in_stall) carries either an echo
// capture edge (op = 0) or a control tick (op = 1). Edges alternate rise and
// fall; a fall turns the pulse width into a distance by a multiplication with
// the reciprocal of the divisor in the next cycle, so the input stalls after
// a falling edge but not after a rising one. A control tick runs the PID
// step and the line sensor decision. The products go one at a time through
// a single shared multiply-add unit under a small sequencer: three PID
// terms, the rounding of the power, two partial products of the trim and two
// saturating wheel sums. A tick is accepted, then occupies the block through
// steps P, I, D, PW, T0, T1, L and R, and its result transfer is offered on
// the output channel (out_valid / out_stall) right after. New input is taken
// only while both the sequencer and the reciprocal stage are idle. The result
// sits in an output register, so a new item may be accepted while the
// previous result waits. If the receiver still stalls when the next tick
// finishes, the sequencer holds in its last step until the register is free.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) that the
// user must write only while idle; the block does not enforce this. An
// asynchronous low reset restores register defaults and clears the echo and
// PID state; no output is valid after reset.
// ----------------------------------------------------------------------------
module line_follow_distance_keeping_drive (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [lfd_pkg::CAP_W-1:0]       capture_time,
    input  logic                            ir_left,
    input  logic                            ir_left_center,
    input  logic                            ir_center,
    input  logic                            ir_right_center,
    input  logic                            ir_right,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lfd_pkg::DUTY_W-1:0]      left_duty,
    output logic [lfd_pkg::DUTY_W-1:0]      right_duty,
    output logic [lfd_pkg::DRV_W-1:0]       drive_state,
    output logic [lfd_pkg::DIST_W-1:0]      distance_cm,
    // configuration
    input  logic                            cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfd_pkg::CFG_W-1:0]       cfg_data
);
    import lfd_pkg::*;

    // Sequencer states: idle and one per step of a tick.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_P    = 9'b000000010,
        ST_I    = 9'b000000100,
        ST_D    = 9'b000001000,
        ST_PW   = 9'b000010000,
        ST_T0   = 9'b000100000,
        ST_T1   = 9'b001000000,
        ST_L    = 9'b010000000,
        ST_R    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [DIST_W-1:0] setpoint_reg;
    logic [DIST_W-1:0] stopdist_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;
    logic [GAIN_W-1:0] trim_reg;
    logic [DIST_W-1:0] windup_reg;

    // PID state
    logic signed [ERR_W-1:0] last_err_reg;
    logic signed [SUM_W-1:0] esum_reg;

    // Per-tick working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic signed [POW_W-1:0]   power_reg;
    logic signed [POW_W-1:0]   power_next;
    drv_t                      drv_reg;
    drv_t                      drv_next;
    logic [DUTY_W-1:0]         left_calc_reg;

    // Output register
    logic              out_valid_reg;
    logic [DUTY_W-1:0] left_duty_reg;
    logic [DUTY_W-1:0] right_duty_reg;
    logic [DRV_W-1:0]  drive_state_reg;
    logic [DIST_W-1:0] distance_reg;

    logic              in_acc;
    logic              tick_acc;
    logic              echo_busy;
    logic [DIST_W-1:0] meas_dist;
    logic              out_free;

    logic signed [ERR_W-1:0]   err_now;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [SUM_W-1:0]   esum_next;
    logic signed [SLOPE_W-1:0] slope_now;
    logic                      clear_sum;
    logic [4:0]                sensors;

    mac_ctl_t                  mac_ctl;
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_sum;
    logic signed [ACC_W-1:0]   mac_acc;
    logic [DUTY_W-1:0]         duty_sat;
    logic [DUTY_W-1:0]         left_pick;
    logic [DUTY_W-1:0]         right_pick;

    // A Q16 wheel sum becomes a duty: negative to zero, floor, cap at the top.
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-FRAC_Q16-1:0] q;
        q = v[ACC_W-1:FRAC_Q16];
        if (v[ACC_W-1])
            return '0;
        else if (q > (ACC_W - FRAC_Q16)'(PWM_TOP))
            return DUTY_W'(PWM_TOP);
        else
            return q[DUTY_W-1:0];
    endfunction

    assign in_stall = (state_reg != ST_IDLE) || echo_busy;
    assign in_acc   = in_valid && !in_stall;
    assign tick_acc = in_acc && op;
    assign out_free = !(out_valid_reg && out_stall);

    lfd_echo u_echo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc && !op),
        .cap      (capture_time),
        .busy     (echo_busy),
        .distance (meas_dist)
    );

    // Error, integral and slope are settled in the cycle the tick is taken.
    always_comb
    begin
        sensors   = {ir_left, ir_left_center, ir_center, ir_right_center, ir_right};
        err_now   = $signed({1'b0, meas_dist}) - $signed({1'b0, setpoint_reg});
        sum_wide  = {esum_reg[SUM_W-1], esum_reg}
                    + {{(SUM_W + 1 - ERR_W){err_now[ERR_W-1]}}, err_now};
        if (!sum_wide[SUM_W] && sum_wide[SUM_W-1])
            sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
        else if (sum_wide[SUM_W] && !sum_wide[SUM_W-1])
            sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
        // The integral is dropped when the error is out of band and small.
        clear_sum = (err_now[ERR_W-1] || (err_now > $signed({1'b0, setpoint_reg})))
                    && (err_now < $signed({1'b0, windup_reg}));
        esum_next = clear_sum ? '0 : sum_sat;
        slope_now = {err_now[ERR_W-1], err_now} - {last_err_reg[ERR_W-1], last_err_reg};

        if ((meas_dist < stopdist_reg) || (sensors == 5'b00000) || (sensors == 5'b11111))
            drv_next = DRV_STOP;
        else if (!ir_left_center)
            drv_next = DRV_LEFT;
        else if (!ir_right_center)
            drv_next = DRV_RIGHT;
        else if (!ir_left)
            drv_next = DRV_SLEFT;
        else if (!ir_right)
            drv_next = DRV_SRIGHT;
        else
            drv_next = DRV_STRAIGHT;
    end

    // Operand selection and unit control for each step.
    always_comb
    begin
        mac_ctl = '{en: 1'b0, csel: C_ZERO, use_acc: 1'b0, shift_hi: 1'b0, negate: 1'b0};
        mac_a   = '0;
        mac_b   = '0;
        unique case (state_reg)
            ST_P:
            begin
                mac_ctl.en = 1'b1;
                mac_a = {{(MUL_A_W - ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mac_b = {1'b0, kp_reg};
            end
            ST_I:
            begin
                mac_ctl.en   = 1'b1;
                mac_ctl.csel = C_ACC;
                mac_a = {{(MUL_A_W - SUM_W){esum_reg[SUM_W-1]}}, esum_reg};
                mac_b = {1'b0, ki_reg};
            end
            ST_D:
            begin
                mac_ctl.en   = 1'b1;
                mac_ctl.csel = C_ACC;
                mac_a = {{(MUL_A_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg};
                mac_b = {1'b0, kd_reg};
            end
            ST_T0:
            begin
                mac_ctl.en = 1'b1;
                mac_a = {{(MUL_A_W - LO_W){1'b0}}, power_reg[LO_W-1:0]};
                mac_b = {1'b0, trim_reg};
            end
            ST_T1:
            begin
                mac_ctl.en       = 1'b1;
                mac_ctl.csel     = C_ACC;
                mac_ctl.shift_hi = 1'b1;
                mac_a = {{(MUL_A_W - HI_W){power_reg[POW_W-1]}}, power_reg[POW_W-1:LO_W]};
                mac_b = {1'b0, trim_reg};
            end
            ST_L:
            begin
                mac_ctl.csel    = C_LEFT;
                mac_ctl.use_acc = 1'b1;
            end
            ST_R:
            begin
                mac_ctl.csel    = C_RIGHT;
                mac_ctl.use_acc = 1'b1;
                mac_ctl.negate  = 1'b1;
            end
            default:
            begin
                mac_ctl.en = 1'b0;
            end
        endcase
    end

    lfd_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .sum (mac_sum),
        .acc (mac_acc)
    );

    // Sum with Q8.8 gains (eight fraction bits) to integer power, truncating toward zero.
    assign power_next = mac_acc[POW_W+FRAC_Q88-1:FRAC_Q88]
                        + POW_W'(mac_acc[ACC_W-1] && (|mac_acc[FRAC_Q88-1:0]));
    assign duty_sat   = clamp_duty(mac_sum);

    // Wheel values per drive state: computed duties when straight, fixed values for the turning and stop states.
    always_comb
    begin
        case (drv_reg)
            DRV_STRAIGHT:
            begin
                left_pick  = left_calc_reg;
                right_pick = duty_sat;
            end
            DRV_LEFT:
            begin
                left_pick  = DUTY_W'(WHEEL_L_LEFT);
                right_pick = DUTY_W'(WHEEL_R_LEFT);
            end
            DRV_RIGHT:
            begin
                left_pick  = DUTY_W'(WHEEL_L_RIGHT);
                right_pick = DUTY_W'(WHEEL_R_RIGHT);
            end
            DRV_SLEFT:
            begin
                left_pick  = '0;
                right_pick = DUTY_W'(WHEEL_R_SHARPLEFT);
            end
            DRV_SRIGHT:
            begin
                left_pick  = DUTY_W'(WHEEL_L_SHARPRIGHT);
                right_pick = '0;
            end
            default:
            begin
                left_pick  = '0;
                right_pick = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (tick_acc) state_next = ST_P;
            ST_P:    state_next = ST_I;
            ST_I:    state_next = ST_D;
            ST_D:    state_next = ST_PW;
            ST_PW:   state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:   state_next = ST_L;
            ST_L:    state_next = ST_R;
            ST_R:    if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and PID state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            setpoint_reg  <= DIST_W'(R_SETPOINT);
            stopdist_reg  <= DIST_W'(R_STOPDIST);
            kp_reg        <= GAIN_W'(R_KP);
            ki_reg        <= GAIN_W'(R_KI);
            kd_reg        <= GAIN_W'(R_KD);
            trim_reg      <= GAIN_W'(R_TRIM);
            windup_reg    <= DIST_W'(R_WINDUP);
            last_err_reg  <= '0;
            esum_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == ST_R) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (tick_acc)
            begin
                last_err_reg <= err_now;
                esum_reg     <= esum_next;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SETPOINT: setpoint_reg <= cfg_data[DIST_W-1:0];
                    CFG_STOPDIST: stopdist_reg <= cfg_data[DIST_W-1:0];
                    CFG_KP:       kp_reg       <= cfg_data[GAIN_W-1:0];
                    CFG_KI:       ki_reg       <= cfg_data[GAIN_W-1:0];
                    CFG_KD:       kd_reg       <= cfg_data[GAIN_W-1:0];
                    CFG_TRIM:     trim_reg     <= cfg_data[GAIN_W-1:0];
                    CFG_WINDUP:   windup_reg   <= cfg_data[DIST_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Working and output payload.
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            err_reg   <= err_now;
            slope_reg <= slope_now;
            drv_reg   <= drv_next;
        end
        if (state_reg == ST_PW)
            power_reg <= power_next;
        if (state_reg == ST_L)
            left_calc_reg <= duty_sat;
        if ((state_reg == ST_R) && out_free)
        begin
            left_duty_reg   <= left_pick;
            right_duty_reg  <= right_pick;
            drive_state_reg <= drv_reg;
            distance_reg    <= meas_dist;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_duty   = left_duty_reg;
    assign right_duty  = right_duty_reg;
    assign drive_state = drive_state_reg;
    assign distance_cm = distance_reg;

`include "line_follow_distance_keeping_drive_assert.svh"

    // A taken tick always starts the PID sequence.
    `LFD_ASSERT_NEXT(a_tick_starts, tick_acc, state_reg == ST_P)
    // The input never transfers while the sequencer is busy.
    `LFD_ASSERT_SAME(a_busy_stalls, state_reg != ST_IDLE, in_stall)
    // Finishing the last step always offers a result and frees the block.
    `LFD_ASSERT_NEXT(a_finish_offers, (state_reg == ST_R) && out_free,
        out_valid && (state_reg == ST_IDLE))
    // Offered duties stay within the compare range.
    `LFD_ASSERT_SAME(a_duty_range, out_valid,
        (left_duty <= DUTY_W'(PWM_TOP)) && (right_duty <= DUTY_W'(PWM_TOP)))

endmodule

@@ sim/drive_duty_checker.sv @@
// ----------------------------------------------------------------------------
// Drive duty checker
// Watches the input, output and configuration ports of the line follow drive.
// It predicts each control tick's wheel duties, drive state and distance, then
// compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module drive_duty_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            op,
    input  logic [lfd_pkg::CAP_W-1:0]       capture_time,
    input  logic                            ir_left,
    input  logic                            ir_left_center,
    input  logic                            ir_center,
    input  logic                            ir_right_center,
    input  logic                            ir_right,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [lfd_pkg::DUTY_W-1:0]      left_duty,
    input  logic [lfd_pkg::DUTY_W-1:0]      right_duty,
    input  logic [lfd_pkg::DRV_W-1:0]       drive_state,
    input  logic [lfd_pkg::DIST_W-1:0]      distance_cm,
    input  logic                            cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfd_pkg::CFG_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import lfd_pkg::*;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    typedef struct {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
        drv_t              state;
        logic [DIST_W-1:0] dist_cm;
    } drive_out_t;

    drive_out_t        expected_duties[$];
    drive_out_t        fresh;
    drive_out_t        oldest;

    // Copy of the configuration registers.
    logic [DIST_W-1:0] setpoint;
    logic [DIST_W-1:0] stop_dist;
    logic [DIST_W-1:0] windup;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] trim_gain;

    // Echo timing and PID state.
    logic              awaiting_rise;
    logic [CAP_W-1:0]  rise_stamp;
    logic [DIST_W-1:0] distance;
    int                prev_error;
    int                error_sum;

    function automatic logic [DUTY_W-1:0] clamp_duty(input longint num);
        longint q;
        if (num < 0)
        begin
            return '0;
        end
        q = num / 65536;
        if (q > PWM_TOP)
        begin
            q = PWM_TOP;
        end
        return q[DUTY_W-1:0];
    endfunction

    task automatic take_echo_edge(input logic [CAP_W-1:0] stamp);
        logic [CAP_W-1:0] width;
        int unsigned      d;
        if (awaiting_rise)
        begin
            rise_stamp    = stamp;
            awaiting_rise = 1'b0;
        end
        else
        begin
            // The subtraction wraps at the timer width.
            width = stamp - rise_stamp;
            d = width / ECHO_DIVISOR;
            if (d > DIST_MAX)
            begin
                d = DIST_MAX;
            end
            distance      = d[DIST_W-1:0];
            awaiting_rise = 1'b1;
        end
    endtask

    task automatic predict_tick(input logic [4:0] ir, output drive_out_t r);
        longint err;
        longint sum;
        longint slope;
        longint acc;
        longint power;
        longint trim;
        logic   sl;
        logic   slc;
        logic   src;
        logic   sr;
        sl  = ir[4];
        slc = ir[3];
        src = ir[1];
        sr  = ir[0];

        err = longint'(distance) - longint'(setpoint);
        sum = longint'(error_sum) + err;
        if (sum > SUM_MAX)
        begin
            sum = SUM_MAX;
        end
        if (sum < SUM_MIN)
        begin
            sum = SUM_MIN;
        end
        error_sum = int'(sum);
        if ((err < 0 || err > longint'(setpoint)) && err < longint'(windup))
        begin
            error_sum = 0;
        end
        slope      = err - longint'(prev_error);
        prev_error = int'(err);
        acc = err * longint'(kp) + longint'(error_sum) * longint'(ki)
            + slope * longint'(kd);
        power = acc / 256;

        if (distance < stop_dist || ~|ir || &ir)
        begin
            r.state = DRV_STOP;
        end
        else if (!slc)
        begin
            r.state = DRV_LEFT;
        end
        else if (!src)
        begin
            r.state = DRV_RIGHT;
        end
        else if (!sl)
        begin
            r.state = DRV_SLEFT;
        end
        else if (!sr)
        begin
            r.state = DRV_SRIGHT;
        end
        else
        begin
            r.state = DRV_STRAIGHT;
        end

        case (r.state)
            DRV_STRAIGHT:
            begin
                trim    = power * longint'(trim_gain);
                r.left  = clamp_duty(longint'(WHEEL_L_STRAIGHT) * 65536 + trim);
                r.right = clamp_duty(longint'(WHEEL_R_STRAIGHT) * 65536 - trim);
            end
            DRV_LEFT:
            begin
                r.left  = DUTY_W'(WHEEL_L_LEFT);
                r.right = DUTY_W'(WHEEL_R_LEFT);
            end
            DRV_RIGHT:
            begin
                r.left  = DUTY_W'(WHEEL_L_RIGHT);
                r.right = DUTY_W'(WHEEL_R_RIGHT);
            end
            DRV_SLEFT:
            begin
                r.left  = '0;
                r.right = DUTY_W'(WHEEL_R_SHARPLEFT);
            end
            DRV_SRIGHT:
            begin
                r.left  = DUTY_W'(WHEEL_L_SHARPRIGHT);
                r.right = '0;
            end
            default:
            begin
                r.left  = '0;
                r.right = '0;
            end
        endcase
        r.dist_cm = distance;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint      = DIST_W'(R_SETPOINT);
            stop_dist     = DIST_W'(R_STOPDIST);
            kp            = GAIN_W'(R_KP);
            ki            = GAIN_W'(R_KI);
            kd            = GAIN_W'(R_KD);
            trim_gain     = GAIN_W'(R_TRIM);
            windup        = DIST_W'(R_WINDUP);
            awaiting_rise = 1'b1;
            rise_stamp    = '0;
            distance      = '0;
            prev_error    = 0;
            error_sum     = 0;
            fail_count    = 0;
            expected_duties.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SETPOINT: setpoint  = cfg_data[DIST_W-1:0];
                    CFG_STOPDIST: stop_dist = cfg_data[DIST_W-1:0];
                    CFG_KP:       kp        = cfg_data[GAIN_W-1:0];
                    CFG_KI:       ki        = cfg_data[GAIN_W-1:0];
                    CFG_KD:       kd        = cfg_data[GAIN_W-1:0];
                    CFG_TRIM:     trim_gain = cfg_data[GAIN_W-1:0];
                    CFG_WINDUP:   windup    = cfg_data[DIST_W-1:0];
                    default:      ;
                endcase
            end

            // Input transfer: an echo edge updates the distance, a tick predicts.
            if (in_valid && !in_stall)
            begin
                if (!op)
                begin
                    take_echo_edge(capture_time);
                end
                else
                begin
                    predict_tick({ir_left, ir_left_center, ir_center,
                                  ir_right_center, ir_right}, fresh);
                    expected_duties.push_back(fresh);
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_duties.size() == 0)
                begin
                    $error("result transfer with no tick awaiting its result");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_duties.pop_front();
                    if (left_duty !== oldest.left)
                    begin
                        $error("left_duty: expected %0d, got %0d", oldest.left, left_duty);
                        fail_count++;
                    end
                    if (right_duty !== oldest.right)
                    begin
                        $error("right_duty: expected %0d, got %0d",
                               oldest.right, right_duty);
                        fail_count++;
                    end
                    if (drive_state !== oldest.state)
                    begin
                        $error("drive_state: expected %0d, got %0d",
                               oldest.state, drive_state);
                        fail_count++;
                    end
                    if (distance_cm !== oldest.dist_cm)
                    begin
                        $error("distance_cm: expected %0d, got %0d",
                               oldest.dist_cm, distance_cm);
                        fail_count++;
                    end
                end
            end
            outstanding <= expected_duties.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Line follow drive testbench
// Drives echo edges and control ticks into the drive under several register
// settings and flow control patterns. A checker beside the block predicts
// every result and reports mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import lfd_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 9;
    // The reciprocal stage keeps the block busy after a falling edge, which
    // produces no result, so this many cycles cover it.
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASE_COUNT   = 8;
    // Generous bound: the slowest legal run stays far below this.
    localparam longint TIMEOUT_NS = 64'd800_000 * 2 * CLK_HALF_NS;
    localparam int DIST_LIMIT    = 1129;

    // Operation codes of the input transfer.
    localparam logic OP_ECHO = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // Sensor patterns, ordered left, left center, center, right center, right.
    localparam logic [4:0] IR_NONE             = 5'b00000;
    localparam logic [4:0] IR_ALL              = 5'b11111;
    localparam logic [4:0] IR_ON_LINE          = 5'b11011;
    localparam logic [4:0] IR_OFF_LEFT_CENTER  = 5'b10111;
    localparam logic [4:0] IR_OFF_RIGHT_CENTER = 5'b11101;
    localparam logic [4:0] IR_OFF_LEFT         = 5'b01111;
    localparam logic [4:0] IR_OFF_RIGHT        = 5'b11110;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [CFG_W-1:0] setpoint;
        logic [CFG_W-1:0] stopdist;
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] ki;
        logic [CFG_W-1:0] kd;
        logic [CFG_W-1:0] trim;
        logic [CFG_W-1:0] windup;
    } drive_cfg_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic                 op              = OP_ECHO;
    logic [CAP_W-1:0]     capture_time    = '0;
    logic                 ir_left         = 1'b0;
    logic                 ir_left_center  = 1'b0;
    logic                 ir_center       = 1'b0;
    logic                 ir_right_center = 1'b0;
    logic                 ir_right        = 1'b0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [DUTY_W-1:0]    left_duty;
    logic [DUTY_W-1:0]    right_duty;
    logic [DRV_W-1:0]     drive_state;
    logic [DIST_W-1:0]    distance_cm;
    logic                 cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [CFG_W-1:0]     cfg_data        = '0;
    int                   fail_count;
    int                   outstanding;

    // Flow control knobs, in percent of cycles.
    int                   send_idle_pct   = 0;
    int                   recv_stall_pct  = 0;
    int                   items_sent      = 0;
    // Setpoint currently loaded, used to aim echo widths near it.
    int                   cur_setpoint    = R_SETPOINT;
    int                   cur_stopdist    = R_STOPDIST;

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    line_follow_distance_keeping_drive dut (.*);

    drive_duty_checker u_duty_check (.*);

    // The receiver stalls at random; a stall never waits for valid.
    always @(posedge clk)
    begin
        out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end

    // Offer one input transfer, after an optional random gap, and hold it until
    // the block takes it. Valid is left high so that back-to-back transfers
    // never lower and raise it within one time step.
    task automatic send(input logic kind, input logic [CAP_W-1:0] stamp,
                        input logic [4:0] ir);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= kind;
        capture_time <= stamp;
        {ir_left, ir_left_center, ir_center, ir_right_center, ir_right} <= ir;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stop sending, wait for every predicted result, then let the distance
    // stage finish any falling edge still in flight.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write every register, plus a write to the spare index with junk data.
    task automatic load_settings(input drive_cfg_t s);
        put_reg(CFG_SETPOINT, s.setpoint);
        put_reg(CFG_STOPDIST, s.stopdist);
        put_reg(CFG_KP, s.kp);
        put_reg(CFG_KI, s.ki);
        put_reg(CFG_KD, s.kd);
        put_reg(CFG_TRIM, s.trim);
        put_reg(CFG_WINDUP, s.windup);
        put_reg(CFG_SPARE_INDEX, CFG_W'($urandom));
        cfg_we       <= 1'b0;
        cur_setpoint  = int'(s.setpoint[DIST_W-1:0]);
        cur_stopdist  = int'(s.stopdist[DIST_W-1:0]);
    endtask

    // Sensors most often sit on the line so that the straight drive and its
    // PID trim get exercised; the rest covers turns and lost-line cases.
    function automatic logic [4:0] pick_sensors();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return IR_ON_LINE;
        end
        if (r < 52)
        begin
            return IR_NONE;
        end
        if (r < 59)
        begin
            return IR_ALL;
        end
        return 5'($urandom);
    endfunction

    // Distances cluster around the setpoint and the stop distance, where the
    // PID band, the integral clear and the stop decision change behavior.
    function automatic int pick_distance();
        int r;
        int span;
        int center;
        int d;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            return $urandom_range(0, DIST_LIMIT);
        end
        center = (r < 80) ? cur_setpoint : cur_stopdist;
        span   = center / 2 + 20;
        d      = center + int'($urandom_range(0, 2 * span)) - span;
        if (d < 0)
        begin
            d = 0;
        end
        if (d > DIST_LIMIT)
        begin
            d = DIST_LIMIT;
        end
        return d;
    endfunction

    // A rise and fall pair whose width gives the wanted distance. The rise
    // stamp is random, so the fall stamp often wraps past the timer top.
    task automatic send_echo(input int dist_want);
        logic [CAP_W-1:0] rise;
        int               width;
        rise  = CAP_W'($urandom);
        width = dist_want * ECHO_DIVISOR + int'($urandom_range(0, ECHO_DIVISOR - 1));
        if (width > (1 << CAP_W) - 1)
        begin
            width = (1 << CAP_W) - 1;
        end
        send(OP_ECHO, rise, pick_sensors());
        send(OP_ECHO, rise + CAP_W'(width), pick_sensors());
    endtask

    function automatic drive_cfg_t phase_settings(input int phase);
        drive_cfg_t s;
        case (phase)
            0:
            begin
                s = '{CFG_W'(R_SETPOINT), CFG_W'(R_STOPDIST), CFG_W'(R_KP),
                      CFG_W'(R_KI), CFG_W'(R_KD), CFG_W'(R_TRIM), CFG_W'(R_WINDUP)};
            end
            1:
            begin
                // All ones: the narrow registers keep only their low bits.
                s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF};
            end
            2:
            begin
                s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            end
            3:
            begin
                // Far setpoint with full P, I and trim gains drives duties to both rails.
                s = '{CFG_W'(DIST_LIMIT), 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                      16'hFFFF, CFG_W'(DIST_LIMIT)};
            end
            default:
            begin
                s.setpoint = CFG_W'($urandom_range(0, 300));
                s.stopdist = CFG_W'($urandom_range(0, s.setpoint));
                s.kp       = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 2048))
                                                         : CFG_W'($urandom);
                s.ki       = CFG_W'($urandom_range(0, 64));
                s.kd       = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 2048))
                                                         : CFG_W'($urandom);
                s.trim     = CFG_W'($urandom);
                s.windup   = CFG_W'($urandom_range(0, 400));
            end
        endcase
        return s;
    endfunction

    // Mostly well-formed measure-then-steer sequences with random content,
    // plus some noise transfers that break the rise/fall pairing.
    task automatic run_phase(input idle_mode_t mode);
        int  start;
        bit  paused;
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 61; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default:       begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < PHASE_ITEMS)
        begin
            // Halfway through, hold off until the block has drained.
            if (!paused && items_sent - start >= PHASE_ITEMS / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
            begin
                send_echo(pick_distance());
                repeat ($urandom_range(1, 3))
                begin
                    send(OP_TICK, CAP_W'($urandom), pick_sensors());
                end
            end
            else
            begin
                send(1'($urandom), CAP_W'($urandom), 5'($urandom));
            end
        end
    endtask

    initial
    begin
        #TIMEOUT_NS;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings, no flow control.
        // A tick before any echo sees distance zero and stops.
        send(OP_TICK, '0, IR_ON_LINE);
        // Widest pulse gives the largest distance and a large positive error.
        send(OP_ECHO, '0, IR_NONE);
        send(OP_ECHO, '1, IR_ALL);
        send(OP_TICK, '0, IR_ON_LINE);
        send(OP_TICK, '1, IR_ON_LINE);
        // The timer wraps between rise and fall.
        send(OP_ECHO, 16'hFFFA, IR_NONE);
        send(OP_ECHO, 16'd100, IR_NONE);
        send(OP_TICK, '0, IR_ON_LINE);
        // Zero width pulse.
        send(OP_ECHO, 16'd1000, IR_NONE);
        send(OP_ECHO, 16'd1000, IR_NONE);
        send(OP_TICK, '0, IR_ALL);
        // A mid distance, then every drive decision.
        send(OP_ECHO, 16'd500, IR_NONE);
        send(OP_ECHO, 16'd500 + CAP_W'(ECHO_DIVISOR * 30 + ECHO_DIVISOR - 1), IR_NONE);
        send(OP_TICK, '0, IR_NONE);
        send(OP_TICK, '0, IR_ALL);
        send(OP_TICK, '0, IR_OFF_LEFT_CENTER);
        send(OP_TICK, '0, IR_OFF_RIGHT_CENTER);
        send(OP_TICK, '0, IR_OFF_LEFT);
        send(OP_TICK, '0, IR_OFF_RIGHT);
        send(OP_TICK, '0, IR_ON_LINE);
        // Just under the setpoint: negative error below the windup limit.
        send(OP_ECHO, 16'd0, IR_NONE);
        send(OP_ECHO, CAP_W'(ECHO_DIVISOR * 9), IR_NONE);
        send(OP_TICK, '0, IR_ON_LINE);

        // Random phases, each under its own settings and flow control pattern.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_for_results();
            load_settings(phase_settings(phase));
            run_phase(idle_mode_t'(phase % 4));
        end
        wait_for_results();

        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
